### design/sm4_block_cipher_defines.svh
// assertion macros used by the sm4 block cipher top level
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SM4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/sm4_pkg.sv
// shared types, constants and round functions of the sm4 block cipher
package sm4_pkg;

  localparam int ROUNDS     = 32;
  localparam int RK_ADDR_W  = $clog2(ROUNDS);
  localparam int WORD_W     = 32;
  localparam int HALF_W     = 64;
  localparam int BLOCK_W    = 128;
  localparam int CFG_IDX_W  = 2;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [RK_ADDR_W-1:0] rk_addr_t;

  localparam rk_addr_t RK_FIRST = '0;
  localparam rk_addr_t RK_LAST  = RK_ADDR_W'(ROUNDS - 1);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // system parameter fk
  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  // s-box, entry 0 in the top byte
  localparam logic [0:255][7:0] SBOX = {
    64'hd690e9fecce13db7, 64'h16b614c228fb2c05,
    64'h2b679a762abe04c3, 64'haa44132649860699,
    64'h9c4250f491ef987a, 64'h33540b43edcfac62,
    64'he4b31ca9c908e895, 64'h80df94fa758f3fa6,
    64'h4707a7fcf37317ba, 64'h83593c19e6854fa8,
    64'h686b81b27164da8b, 64'hf8eb0f4b70569d35,
    64'h1e240e5e6358d1a2, 64'h25227c3b01217887,
    64'hd40046579fd32752, 64'h4c3602e7a0c4c89e,
    64'heabf8ad240c738b5, 64'ha3f7f2cef96115a1,
    64'he0ae5da49b341a55, 64'had933230f58cb1e3,
    64'h1df6e22e8266ca60, 64'hc02923ab0d534e6f,
    64'hd5db3745defd8e2f, 64'h03ff6a726d6c5b51,
    64'h8d1baf92bbddbc7f, 64'h11d95c411f105ad8,
    64'h0ac13188a5cd7bbd, 64'h2d74d012b8e5b4b0,
    64'h8969974a0c96777e, 64'h65b9f109c56ec684,
    64'h18f07dec3adc4d20, 64'h79ee5f3ed7cb3948
  };

  function automatic word_t sub_word(input word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // linear transform of the data rounds
  function automatic word_t lin_data(input word_t b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // linear transform of the key schedule
  function automatic word_t lin_key(input word_t b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // ck byte j of round i is (4i + j) * 7 mod 256
  function automatic word_t ck_word(input rk_addr_t i);
    word_t     w;
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    return w;
  endfunction

endpackage

### design/sm4_ram.sv
// generic single-write, single-read memory with registered read data
module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sm4_round.sv
// shared round unit: w0 ^ t(w1 ^ w2 ^ w3 ^ rk), data or key-schedule transform
module sm4_round import sm4_pkg::*; (
  input  logic  key_mode,
  input  word_t w0,
  input  word_t w1,
  input  word_t w2,
  input  word_t w3,
  input  word_t rk,
  output word_t nx
);

  word_t sbox_out;

  always_comb begin
    sbox_out = sub_word(w1 ^ w2 ^ w3 ^ rk);
    nx = w0 ^ (key_mode ? lin_key(sbox_out) : lin_data(sbox_out));
  end

endmodule

### design/sm4_block_cipher.sv
// top level of the sm4 block cipher: control, block state and round key memory
//
//  channel  direction  handshake                fields
//  s_*      in         s_tvalid / s_tready      tuser: operation; tdata: block_high, block_low
//  m_*      out        m_tvalid / m_tready      tdata: result_high, result_low
//  cfg_*    in         cfg_we (no wait)         cfg_index 0 key_high, 1 key_low; cfg_data
//
// with the round keys ready, a request passes through one memory read set-up,
// 32 rounds (one per cycle, round key memory read one round ahead) and then into
// the output register.
// the next request is taken only once the sequencer is back in idle, so one block at a time.
// the first block after reset or a key write first runs the key expansion.
// rst is synchronous; afterwards the key is all zero and not yet expanded.
// a finished block waits while the output register still holds an untaken result.

`include "sm4_block_cipher_defines.svh"

module sm4_block_cipher import sm4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BLOCK_W-1:0]   s_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic [0:0]           s_tuser,   // [0] operation
  // result side
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BLOCK_W-1:0]   m_tdata,   // [63:0] result_high, [127:64] result_low
  // key registers
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data
);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t      state;
  rk_addr_t    cnt;
  logic        keys_expanded;
  logic        decrypt;
  logic [HALF_W-1:0] key_high;
  logic [HALF_W-1:0] key_low;

  // block words and key-schedule words, shifted by one each round
  word_t       x [4];
  word_t       k [4];

  logic [BLOCK_W-1:0] out_data;
  logic               out_valid;

  logic        s_accept;
  logic        key_mode;
  rk_addr_t    cnt_inc;
  rk_addr_t    rd_addr;
  word_t       rk_rdata;
  word_t       rnd_rk;
  word_t       rnd_out;
  word_t       rnd_w [4];

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign key_mode = (state == ST_EXPAND);
  assign cnt_inc  = cnt + RK_ADDR_W'(1);

  // round key read address, one round ahead; decryption walks the store backwards
  always_comb begin
    case (state)
      ST_LOAD:  rd_addr = (decrypt == OP_DECRYPT) ? RK_LAST : RK_FIRST;
      ST_ROUND: rd_addr = (decrypt == OP_DECRYPT) ? (RK_LAST - cnt_inc) : cnt_inc;
      default:  rd_addr = RK_FIRST;
    endcase
  end

  // the round unit serves the key schedule and the data rounds in turn
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd_w[i] = key_mode ? k[i] : x[i];
    end
    rnd_rk = key_mode ? ck_word(cnt) : rk_rdata;
  end

  sm4_round u_round (
    .key_mode (key_mode),
    .w0       (rnd_w[0]),
    .w1       (rnd_w[1]),
    .w2       (rnd_w[2]),
    .w3       (rnd_w[3]),
    .rk       (rnd_rk),
    .nx       (rnd_out)
  );

  // round key store, written in order during expansion
  sm4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (key_mode),
    .waddr (cnt),
    .wdata (rnd_out),
    .raddr (rd_addr),
    .rdata (rk_rdata)
  );

  // control and key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      keys_expanded <= 1'b0;
      key_high      <= '0;
      key_low       <= '0;
      out_valid     <= 1'b0;
    end else begin
      // key writes must come only while idle, else they race the sequencer; not enforced
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LOW:  key_low  <= cfg_data;
          default: ;
        endcase
      end

      // a key write forces a fresh expansion before the next block
      if (cfg_we && (cfg_index inside {REG_KEY_HIGH, REG_KEY_LOW})) begin
        keys_expanded <= 1'b0;
      end else if (state == ST_EXPAND && cnt == RK_LAST) begin
        keys_expanded <= 1'b1;
      end

      // output register: filled by a finished block, emptied when taken
      if (state == ST_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            cnt   <= '0;
            state <= keys_expanded ? ST_LOAD : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          cnt <= cnt_inc;
          if (cnt == RK_LAST) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // first round key read is under way
          cnt   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          cnt <= cnt_inc;
          if (cnt == RK_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the output register to be free
          if (!out_valid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          decrypt <= s_tuser[0];
          x[0]    <= s_tdata[63:32];
          x[1]    <= s_tdata[31:0];
          x[2]    <= s_tdata[127:96];
          x[3]    <= s_tdata[95:64];
          k[0]    <= key_high[63:32] ^ FK0;
          k[1]    <= key_high[31:0] ^ FK1;
          k[2]    <= key_low[63:32] ^ FK2;
          k[3]    <= key_low[31:0] ^ FK3;
        end
      end
      ST_EXPAND: begin
        k[0] <= k[1];
        k[1] <= k[2];
        k[2] <= k[3];
        k[3] <= rnd_out;
      end
      ST_ROUND: begin
        x[0] <= x[1];
        x[1] <= x[2];
        x[2] <= x[3];
        x[3] <= rnd_out;
      end
      ST_DONE: begin
        // reversed word order: result_high = x3:x2, result_low = x1:x0
        if (!out_valid || m_tready) begin
          out_data <= {x[1], x[0], x[3], x[2]};
        end
      end
      default: ;
    endcase
  end

  // checks
  `SM4_ASSERT_NEXT(a_expand_first, s_accept && !keys_expanded, state == ST_EXPAND, "block started without expanding the key")
  `SM4_ASSERT_SAME(a_round_keys_ready, state == ST_ROUND || state == ST_LOAD, keys_expanded, "round key store read before expansion")
  `SM4_ASSERT_NEXT(a_last_round, state == ST_ROUND && cnt == RK_LAST, state == ST_DONE && cnt == RK_FIRST, "round count did not end the block")
  `SM4_ASSERT_NEXT(a_result_loaded, state == ST_DONE && (!out_valid || m_tready), out_valid && state == ST_IDLE, "finished block not moved to the output register")

endmodule
